[hdl/cot_pkg.sv]
// Shared types and constants for the capsule overlap test.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cot_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 30;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int LIM_W     = 2 * RSUM_W;
    localparam int OUT_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Internal arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
    localparam int LEN_W   = 66;               // sum of three squares
    localparam int DOT_W   = 67;               // signed sum of three products
    localparam int T_FRAC  = 32;               // projection fraction bits
    localparam int T_W     = T_FRAC + 1;       // projection, 0 .. 1.0
    localparam int ERR_W   = DIFF_W + 2;       // error vector component
    localparam int EMAG_W  = ERR_W - 1;
    localparam int ESQ_W   = 2 * EMAG_W;
    localparam int DIST_W  = ESQ_W + 2;

    // Pipeline depths
    localparam int PT_LAT  = 3 + T_FRAC + 4;   // point-to-segment unit
    localparam int RED_LAT = 4;                // min tree and output stage
    localparam int N_UNITS = 6;

    localparam int DEF_COORD_FRAC_BITS = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RAD_W-1:0]          radius_t;
    typedef logic [DIST_W-1:0]         dist_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_START_X = 3'd0,
        REG_OWN_START_Y = 3'd1,
        REG_OWN_START_Z = 3'd2,
        REG_OWN_END_X   = 3'd3,
        REG_OWN_END_Y   = 3'd4,
        REG_OWN_END_Z   = 3'd5,
        REG_OWN_RADIUS  = 3'd6
    } cfg_reg_t;

    // Reset values of the own capsule
    localparam coord_t  RST_START_Z = -32'sd6553600;
    localparam coord_t  RST_END_Z   = 32'sd6553600;
    localparam radius_t RST_RADIUS  = 30'd3276800;

    // Query kinds
    localparam logic KIND_SPHERE  = 1'b0;
    localparam logic KIND_CAPSULE = 1'b1;

endpackage

[hdl/cot_if.sv]
// Valid/ready channel interfaces for query and result words.
// Depends on cot_pkg.
`timescale 1ns / 1ps

interface cot_query_if;
    import cot_pkg::*;
    logic    valid;
    logic    ready;
    logic    kind;
    coord_t  other_start_x;
    coord_t  other_start_y;
    coord_t  other_start_z;
    coord_t  other_end_x;
    coord_t  other_end_y;
    coord_t  other_end_z;
    radius_t other_radius;

    modport source (
        output valid, kind, other_start_x, other_start_y, other_start_z,
               other_end_x, other_end_y, other_end_z, other_radius,
        input  ready
    );
    modport sink (
        input  valid, kind, other_start_x, other_start_y, other_start_z,
               other_end_x, other_end_y, other_end_z, other_radius,
        output ready
    );
endinterface

interface cot_result_if;
    import cot_pkg::*;
    logic             valid;
    logic             ready;
    logic             overlap;
    logic [OUT_W-1:0] distance_sq;

    modport source (output valid, overlap, distance_sq, input ready);
    modport sink   (input valid, overlap, distance_sq, output ready);
endinterface

[hdl/capsule_overlap_test_top.sv]
// Top level of the capsule overlap test: configuration, input stage,
// six point-to-segment pipes, reduction and output skid buffer.
// Depends on cot_pkg, cot_if, cot_pt_seg and cot_reduce.
`timescale 1ns / 1ps

// One query word in, one result word out, one word per cycle sustained while
// the skid entry is empty. Before the output register lie one input
// stage, 39 stages of point-to-segment distance (32 of them are the
// one-bit-per-stage projection divider) and four stages of minimum, compare
// and saturation. The whole pipe advances together; a two-entry output buffer
// lets a new query be taken while a result waits, and the pipe holds only when
// both entries are full. The user writes configuration through wr_en/wr_index/
// wr_data only while no query is in flight; the block does not enforce this.

module capsule_overlap_test_top #(
    parameter int COORD_FRAC_BITS = cot_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [cot_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [cot_pkg::CFG_W-1:0]     wr_data,
    cot_query_if.sink                     query,
    cot_result_if.source                  result
);
    import cot_pkg::*;

    localparam int LAT = 1 + PT_LAT + RED_LAT;

    // Own capsule registers
    coord_t  own_start_reg [3];
    coord_t  own_end_reg [3];
    radius_t own_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_start_reg[0] <= '0;
            own_start_reg[1] <= '0;
            own_start_reg[2] <= RST_START_Z;
            own_end_reg[0]   <= '0;
            own_end_reg[1]   <= '0;
            own_end_reg[2]   <= RST_END_Z;
            own_radius_reg   <= RST_RADIUS;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_OWN_START_X: own_start_reg[0] <= wr_data;
                REG_OWN_START_Y: own_start_reg[1] <= wr_data;
                REG_OWN_START_Z: own_start_reg[2] <= wr_data;
                REG_OWN_END_X:   own_end_reg[0]   <= wr_data;
                REG_OWN_END_Y:   own_end_reg[1]   <= wr_data;
                REG_OWN_END_Z:   own_end_reg[2]   <= wr_data;
                REG_OWN_RADIUS:  own_radius_reg   <= wr_data[RAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipe enable: hold only when the skid entry is occupied
    logic en;
    logic out_v_reg, skid_v_reg;

    assign en          = !skid_v_reg;
    assign query.ready = en;

    // Valid line through the whole pipe
    logic vld_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= query.valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Input stage and side line for kind and radius sum
    coord_t            os_reg [3];
    coord_t            oe_reg [3];
    logic              kind_reg [PT_LAT+1];
    logic [RSUM_W-1:0] rsum_reg [PT_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            os_reg[0]   <= query.other_start_x;
            os_reg[1]   <= query.other_start_y;
            os_reg[2]   <= query.other_start_z;
            oe_reg[0]   <= query.other_end_x;
            oe_reg[1]   <= query.other_end_y;
            oe_reg[2]   <= query.other_end_z;
            kind_reg[0] <= query.kind;
            rsum_reg[0] <= RSUM_W'(own_radius_reg) + RSUM_W'(query.other_radius);
            for (int i = 1; i <= PT_LAT; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
                rsum_reg[i] <= rsum_reg[i-1];
            end
        end
    end

    // Midpoints, floor of half the sum
    logic signed [DIFF_W-1:0] msum_own_c [3];
    logic signed [DIFF_W-1:0] msum_oth_c [3];
    coord_t                   mid_own_c [3];
    coord_t                   mid_oth_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            msum_own_c[i] = {own_start_reg[i][COORD_W-1], own_start_reg[i]}
                          + {own_end_reg[i][COORD_W-1], own_end_reg[i]};
            msum_oth_c[i] = {os_reg[i][COORD_W-1], os_reg[i]}
                          + {oe_reg[i][COORD_W-1], oe_reg[i]};
            mid_own_c[i]  = msum_own_c[i][DIFF_W-1:1];
            mid_oth_c[i]  = msum_oth_c[i][DIFF_W-1:1];
        end
    end

    // Six point-to-segment pipes; unit 3 alone serves sphere queries
    dist_t seg_dsq [N_UNITS];

    cot_pt_seg u_pt0 (.clk(clk), .en(en), .p(own_start_reg), .a(os_reg), .b(oe_reg),
                      .dsq(seg_dsq[0]));
    cot_pt_seg u_pt1 (.clk(clk), .en(en), .p(own_end_reg), .a(os_reg), .b(oe_reg),
                      .dsq(seg_dsq[1]));
    cot_pt_seg u_pt2 (.clk(clk), .en(en), .p(mid_own_c), .a(os_reg), .b(oe_reg),
                      .dsq(seg_dsq[2]));
    cot_pt_seg u_pt3 (.clk(clk), .en(en), .p(os_reg), .a(own_start_reg),
                      .b(own_end_reg), .dsq(seg_dsq[3]));
    cot_pt_seg u_pt4 (.clk(clk), .en(en), .p(oe_reg), .a(own_start_reg),
                      .b(own_end_reg), .dsq(seg_dsq[4]));
    cot_pt_seg u_pt5 (.clk(clk), .en(en), .p(mid_oth_c), .a(own_start_reg),
                      .b(own_end_reg), .dsq(seg_dsq[5]));

    // Reduction
    logic             red_ovl;
    logic [OUT_W-1:0] red_dsq;

    cot_reduce #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_reduce (
        .clk        (clk),
        .en         (en),
        .kind       (kind_reg[PT_LAT]),
        .rsum       (rsum_reg[PT_LAT]),
        .dsq        (seg_dsq),
        .overlap    (red_ovl),
        .distance_sq(red_dsq)
    );

    // Output register plus skid entry
    logic             out_ovl_reg, skid_ovl_reg;
    logic [OUT_W-1:0] out_dsq_reg, skid_dsq_reg;
    logic             deliver, take;

    assign deliver = en && vld_reg[LAT-1];
    assign take    = out_v_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (take && skid_v_reg)
                skid_v_reg <= 1'b0;
            else if (deliver && out_v_reg && !take)
                skid_v_reg <= 1'b1;
            if (take && !skid_v_reg && !deliver)
                out_v_reg <= 1'b0;
            else if (deliver)
                out_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && skid_v_reg)
        begin
            out_ovl_reg <= skid_ovl_reg;
            out_dsq_reg <= skid_dsq_reg;
        end
        else if (deliver && (!out_v_reg || take))
        begin
            out_ovl_reg <= red_ovl;
            out_dsq_reg <= red_dsq;
        end
        if (deliver && out_v_reg && !take)
        begin
            skid_ovl_reg <= red_ovl;
            skid_dsq_reg <= red_dsq;
        end
    end

    assign result.valid       = out_v_reg;
    assign result.overlap     = out_ovl_reg;
    assign result.distance_sq = out_dsq_reg;

endmodule

[hdl/cot_pt_seg.sv]
// Pipelined squared distance from a point to a segment.
// Depends on cot_pkg; the whole pipe advances on en.
`timescale 1ns / 1ps

module cot_pt_seg (
    input  logic            clk,
    input  logic            en,
    input  cot_pkg::coord_t p [3],
    input  cot_pkg::coord_t a [3],
    input  cot_pkg::coord_t b [3],
    output cot_pkg::dist_t  dsq
);
    import cot_pkg::*;

    typedef enum logic [1:0] {T_ZERO, T_ONE, T_DIV} tmode_t;

    // Stage 1: segment vector and point offset
    logic signed [DIFF_W-1:0] st1_s_reg [3];
    logic signed [DIFF_W-1:0] st1_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st1_s_reg[i] <= {b[i][COORD_W-1], b[i]} - {a[i][COORD_W-1], a[i]};
                st1_d_reg[i] <= {p[i][COORD_W-1], p[i]} - {a[i][COORD_W-1], a[i]};
            end
        end
    end

    // Stage 2: products s*s and d*s
    logic signed [PROD_W-1:0] ss_c [3];
    logic signed [PROD_W-1:0] ds_c [3];
    logic [PROD_W-1:0]        st2_ss_reg [3];
    logic signed [PROD_W-1:0] st2_ds_reg [3];
    logic signed [DIFF_W-1:0] st2_s_reg [3];
    logic signed [DIFF_W-1:0] st2_d_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ss_c[i] = st1_s_reg[i] * st1_s_reg[i];
            ds_c[i] = st1_d_reg[i] * st1_s_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st2_ss_reg[i] <= PROD_W'(ss_c[i]);
                st2_ds_reg[i] <= ds_c[i];
                st2_s_reg[i]  <= st1_s_reg[i];
                st2_d_reg[i]  <= st1_d_reg[i];
            end
        end
    end

    // Stage 3: length, dot product, projection case
    logic [LEN_W-1:0]        len_c;
    logic signed [DOT_W-1:0] dot_c;
    tmode_t                  mode_c;

    always_comb
    begin
        len_c = LEN_W'(st2_ss_reg[0]) + LEN_W'(st2_ss_reg[1]) + LEN_W'(st2_ss_reg[2]);
        dot_c = {st2_ds_reg[0][PROD_W-1], st2_ds_reg[0]}
              + {st2_ds_reg[1][PROD_W-1], st2_ds_reg[1]}
              + {st2_ds_reg[2][PROD_W-1], st2_ds_reg[2]};
        if (len_c == '0 || dot_c[DOT_W-1] || dot_c == '0)
            mode_c = T_ZERO;
        else if (dot_c[LEN_W-1:0] >= len_c)
            mode_c = T_ONE;
        else
            mode_c = T_DIV;
    end

    // Divider chain: index 0 is stage 3, one quotient bit per stage after it
    logic [LEN_W-1:0]         dv_len_reg  [T_FRAC+1];
    logic [LEN_W-1:0]         dv_rem_reg  [T_FRAC+1];
    logic [T_FRAC-1:0]        dv_quo_reg  [T_FRAC+1];
    tmode_t                   dv_mode_reg [T_FRAC+1];
    logic signed [DIFF_W-1:0] dv_s_reg    [T_FRAC+1][3];
    logic signed [DIFF_W-1:0] dv_d_reg    [T_FRAC+1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_len_reg[0]  <= len_c;
            dv_rem_reg[0]  <= dot_c[LEN_W-1:0];
            dv_quo_reg[0]  <= '0;
            dv_mode_reg[0] <= mode_c;
            for (int i = 0; i < 3; i++)
            begin
                dv_s_reg[0][i] <= st2_s_reg[i];
                dv_d_reg[0][i] <= st2_d_reg[i];
            end
        end
    end

    for (genvar k = 0; k < T_FRAC; k++)
    begin : g_div
        logic [LEN_W:0] sh_c;
        logic [LEN_W:0] diff_c;
        logic           ge_c;

        always_comb
        begin
            sh_c   = {dv_rem_reg[k], 1'b0};
            ge_c   = (sh_c >= {1'b0, dv_len_reg[k]});
            diff_c = sh_c - {1'b0, dv_len_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_rem_reg[k+1]  <= ge_c ? diff_c[LEN_W-1:0] : sh_c[LEN_W-1:0];
                dv_quo_reg[k+1]  <= {dv_quo_reg[k][T_FRAC-2:0], ge_c};
                dv_mode_reg[k+1] <= dv_mode_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    dv_s_reg[k+1][i] <= dv_s_reg[k][i];
                    dv_d_reg[k+1][i] <= dv_d_reg[k][i];
                end
            end
        end
    end

    // Stage M: rounded |s| * t
    logic [T_W-1:0]           t_c;
    logic [DIFF_W-1:0]        smag_c [3];
    logic [PROD_W-1:0]        pr_c [3];
    logic [DIFF_W-1:0]        m_q_reg [3];
    logic                     m_neg_reg [3];
    logic signed [DIFF_W-1:0] m_d_reg [3];

    always_comb
    begin
        case (dv_mode_reg[T_FRAC])
            T_ONE:   t_c = T_W'(1) << T_FRAC;
            T_DIV:   t_c = {1'b0, dv_quo_reg[T_FRAC]};
            default: t_c = '0;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            smag_c[i] = dv_s_reg[T_FRAC][i][DIFF_W-1] ? DIFF_W'(-dv_s_reg[T_FRAC][i])
                                                      : DIFF_W'(dv_s_reg[T_FRAC][i]);
            pr_c[i]   = PROD_W'(smag_c[i]) * PROD_W'(t_c)
                      + (PROD_W'(1) << (T_FRAC - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_q_reg[i]   <= pr_c[i][T_FRAC+DIFF_W-1:T_FRAC];
                m_neg_reg[i] <= dv_s_reg[T_FRAC][i][DIFF_W-1];
                m_d_reg[i]   <= dv_d_reg[T_FRAC][i];
            end
        end
    end

    // Stage E: error vector d - q*sign(s)
    logic signed [ERR_W-1:0] qs_c [3];
    logic signed [ERR_W-1:0] e_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            qs_c[i] = m_neg_reg[i] ? -$signed({2'b00, m_q_reg[i]})
                                   : $signed({2'b00, m_q_reg[i]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                e_reg[i] <= {{2{m_d_reg[i][DIFF_W-1]}}, m_d_reg[i]} - qs_c[i];
        end
    end

    // Stage Q: squares of the error components
    logic [ERR_W-1:0] emag_c [3];
    logic [ESQ_W-1:0] sq_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            emag_c[i] = e_reg[i][ERR_W-1] ? ERR_W'(-e_reg[i]) : ERR_W'(e_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= ESQ_W'(emag_c[i][EMAG_W-1:0]) * ESQ_W'(emag_c[i][EMAG_W-1:0]);
        end
    end

    // Stage A: sum of squares
    logic [DIST_W-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
    end

    assign dsq = dist_reg;

endmodule

[hdl/cot_reduce.sv]
// Minimum over the six distances (unit 3 alone for sphere queries), radius compare and output saturation.
// Depends on cot_pkg; four register stages advancing on en.
`timescale 1ns / 1ps

module cot_reduce #(
    parameter int COORD_FRAC_BITS = cot_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        kind,
    input  logic [cot_pkg::RSUM_W-1:0]  rsum,
    input  cot_pkg::dist_t              dsq [cot_pkg::N_UNITS],
    output logic                        overlap,
    output logic [cot_pkg::OUT_W-1:0]   distance_sq
);
    import cot_pkg::*;

    function automatic dist_t dmin(input dist_t x, input dist_t y);
        return (x <= y) ? x : y;
    endfunction

    // R1: pairwise minimum, squared radius sum
    dist_t            r1_a_reg, r1_b_reg, r1_c_reg, r1_pt_reg;
    logic [LIM_W-1:0] r1_lim_reg;
    logic             r1_kind_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_a_reg    <= dmin(dsq[0], dsq[1]);
            r1_b_reg    <= dmin(dsq[2], dsq[4]);
            r1_c_reg    <= dmin(dsq[3], dsq[5]);
            r1_pt_reg   <= dsq[3];
            r1_lim_reg  <= LIM_W'(rsum) * LIM_W'(rsum);
            r1_kind_reg <= kind;
        end
    end

    // R2: second level
    dist_t            r2_ab_reg, r2_c_reg, r2_pt_reg;
    logic [LIM_W-1:0] r2_lim_reg;
    logic             r2_kind_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_ab_reg   <= dmin(r1_a_reg, r1_b_reg);
            r2_c_reg    <= r1_c_reg;
            r2_pt_reg   <= r1_pt_reg;
            r2_lim_reg  <= r1_lim_reg;
            r2_kind_reg <= r1_kind_reg;
        end
    end

    // R3: pick sphere distance or capsule minimum
    dist_t            r3_dist_reg;
    logic [LIM_W-1:0] r3_lim_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_dist_reg <= (r2_kind_reg == KIND_CAPSULE) ? dmin(r2_ab_reg, r2_c_reg)
                                                         : r2_pt_reg;
            r3_lim_reg  <= r2_lim_reg;
        end
    end

    // R4: overlap compare on full precision, scaled and saturated distance
    dist_t            sh_c;
    logic             r4_ovl_reg;
    logic [OUT_W-1:0] r4_dsq_reg;

    assign sh_c = r3_dist_reg >> COORD_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r4_ovl_reg <= (r3_dist_reg <= DIST_W'(r3_lim_reg));
            r4_dsq_reg <= (|sh_c[DIST_W-1:OUT_W]) ? '1 : sh_c[OUT_W-1:0];
        end
    end

    assign overlap     = r4_ovl_reg;
    assign distance_sq = r4_dsq_reg;

endmodule
